// ===== hdl/md5s_pkg.sv =====
// ----------------------------------------------------------------------------
// md5s_pkg: shared types, constants and round tables for the MD5 stream hasher
// Holds the initial chaining values, the per-round sine constants, shift
// amounts and message word schedule, plus the sequencer state encoding.
// ----------------------------------------------------------------------------
package md5s_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 61;
  localparam int unsigned ROUND_W  = 6;
  localparam int unsigned WIDX_W   = 4;
  localparam int unsigned BPTR_W   = 6;

  localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

  localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h80;
  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
  localparam logic [BPTR_W-1:0] LEN_START  = 6'd56;
  localparam logic [BPTR_W-1:0] BLOCK_LAST = 6'd63;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] WORD_IDX_LAST = 2'd3;

  // one-hot sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD   = 8'b0000_0010,
    S_ZERO  = 8'b0000_0100,
    S_LEN   = 8'b0000_1000,
    S_LOAD  = 8'b0001_0000,
    S_ROUND = 8'b0010_0000,
    S_ADD   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  // where the sequencer goes once a compression finishes
  typedef enum logic [1:0] {
    AFT_IDLE = 2'd0,
    AFT_PAD  = 2'd1,
    AFT_ZERO = 2'd2,
    AFT_OUT  = 2'd3
  } after_t;

  function automatic logic [WORD_W-1:0] md5s_k(input logic [ROUND_W-1:0] r);
    logic [WORD_W-1:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5s_rot(input logic [ROUND_W-1:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by each round, modulo 16
  function automatic logic [WIDX_W-1:0] md5s_widx(input logic [ROUND_W-1:0] r);
    logic [WIDX_W-1:0] lo;
    logic [WIDX_W-1:0] w;
    lo = r[WIDX_W-1:0];
    unique case (r[5:4])
      2'd0:    w = lo;
      2'd1:    w = WIDX_W'((lo << 2) + lo + 4'd1);
      2'd2:    w = WIDX_W'((lo << 1) + lo + 4'd5);
      2'd3:    w = WIDX_W'((lo << 3) - lo);
      default: w = lo;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/md5s_in_if.sv =====
// ----------------------------------------------------------------------------
// md5s_in_if: message byte channel
// Valid/ready handshake carrying one message byte and its two flags per item.
// ----------------------------------------------------------------------------
interface md5s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output message_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input message_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

// ===== hdl/md5s_out_if.sv =====
// ----------------------------------------------------------------------------
// md5s_out_if: digest word channel
// Valid/ready handshake carrying one 32-bit digest word per item.
// ----------------------------------------------------------------------------
interface md5s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        final_word;

  modport source (output valid, output digest_word, output word_index,
                  output final_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input final_word, output ready);
endinterface

// ===== hdl/md5_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hasher: streaming MD5 digest engine, one message byte per item
// A data byte is written straight into the block buffer; the byte that fills a
//   64-byte block starts a compression (prefetch, rounds, chaining add) first.
// End of message: padding writes the 0x80, the zeros and the length bytes in
//   turn (the zeros and length may spill into a second block), then one or two compressions,
//   then 4 digest items, one per cycle while the receiver is ready.
// No byte is taken during a compression or until the digest is delivered; every
//   block is compressed on the single shared round unit.
// Reset (rst_n low, synchronous): chaining words to the MD5 IV, count to zero.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
  input logic        clk,
  input logic        rst_n,
  md5s_in_if.sink    in_bus,
  md5s_out_if.source out_bus
);
  import md5s_pkg::*;

  // sequencer
  state_t             state_r, state_nxt;
  after_t             after_r, after_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [BPTR_W-1:0]  ptr_r, ptr_nxt;     // padding write pointer
  logic               wrap_r, wrap_nxt;   // padding runs to end of block first

  // hash state
  logic [WORD_W-1:0]  chain_r [4];
  logic [WORD_W-1:0]  chain_nxt [4];
  logic [WORD_W-1:0]  work_r [4];
  logic [WORD_W-1:0]  work_nxt [4];
  logic [COUNT_W-1:0] count_r, count_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_idx_r, out_idx_nxt;

  // block buffer: 16 little-endian words, written one byte at a time
  logic [WORD_W-1:0]  blk_mem [16];
  logic [WORD_W-1:0]  mem_rdata_r;
  logic               mem_we;
  logic [BPTR_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;
  logic [WIDX_W-1:0]  mem_raddr;

  // round unit
  logic [WORD_W-1:0]  rf;
  logic [WORD_W-1:0]  rsum;
  logic [2*WORD_W-1:0] rdup;
  logic [WORD_W-1:0]  rrot;
  logic [63:0]        bit_len;

  logic in_fire;
  logic out_fire;

  assign in_bus.ready        = (state_r == S_IDLE);
  assign in_fire             = in_bus.valid && in_bus.ready;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.digest_word = chain_r[out_idx_r];
  assign out_bus.word_index  = out_idx_r;
  assign out_bus.final_word  = (out_idx_r == WORD_IDX_LAST);
  assign out_fire            = out_valid_r && out_bus.ready;

  assign bit_len = {count_r, 3'b000};

  // one MD5 round on the working words; message word was prefetched last cycle
  always_comb begin
    unique case (round_r[5:4])
      2'd0:    rf = work_r[3] ^ (work_r[1] & (work_r[2] ^ work_r[3]));
      2'd1:    rf = work_r[2] ^ (work_r[3] & (work_r[1] ^ work_r[2]));
      2'd2:    rf = work_r[1] ^ work_r[2] ^ work_r[3];
      2'd3:    rf = work_r[2] ^ (work_r[1] | ~work_r[3]);
      default: rf = '0;
    endcase
    rsum = work_r[0] + rf + md5s_k(round_r) + mem_rdata_r;
    rdup = {rsum, rsum} << md5s_rot(round_r);
    rrot = rdup[2*WORD_W-1:WORD_W];
  end

  // read address runs one round ahead of the round unit
  always_comb begin
    if (state_r == S_ROUND) begin
      mem_raddr = md5s_widx(round_r + ROUND_W'(1));
    end else begin
      mem_raddr = md5s_widx('0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    round_nxt     = round_r;
    ptr_nxt       = ptr_r;
    wrap_nxt      = wrap_r;
    count_nxt     = count_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = ZERO_BYTE;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_bus.byte_present) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[BPTR_W-1:0];
            mem_wdata = in_bus.message_byte;
            count_nxt = count_r + COUNT_W'(1);
            if (count_nxt[BPTR_W-1:0] == '0) begin
              // block full: compress now, pad afterwards if this was the end
              state_nxt = S_LOAD;
              after_nxt = in_bus.end_of_message ? AFT_PAD : AFT_IDLE;
            end else if (in_bus.end_of_message) begin
              state_nxt = S_PAD;
            end
          end else if (in_bus.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = count_r[BPTR_W-1:0];
        mem_wdata = PAD_BYTE;
        ptr_nxt   = count_r[BPTR_W-1:0] + BPTR_W'(1);
        if (count_r[BPTR_W-1:0] == BLOCK_LAST) begin
          // 0x80 took the last slot: no room for the length
          state_nxt = S_LOAD;
          after_nxt = AFT_ZERO;
          wrap_nxt  = 1'b0;
        end else begin
          state_nxt = S_ZERO;
          wrap_nxt  = (count_r[BPTR_W-1:3] == 3'b111);
        end
      end

      S_ZERO: begin
        if (wrap_r) begin
          mem_we  = 1'b1;
          ptr_nxt = ptr_r + BPTR_W'(1);
          if (ptr_r == BLOCK_LAST) begin
            state_nxt = S_LOAD;
            after_nxt = AFT_ZERO;
            wrap_nxt  = 1'b0;
          end
        end else if (ptr_r == LEN_START) begin
          state_nxt = S_LEN;
        end else begin
          mem_we  = 1'b1;
          ptr_nxt = ptr_r + BPTR_W'(1);
        end
      end

      S_LEN: begin
        mem_we    = 1'b1;
        mem_wdata = bit_len[{ptr_r[2:0], 3'b000} +: BYTE_W];
        ptr_nxt   = ptr_r + BPTR_W'(1);
        if (ptr_r == BLOCK_LAST) begin
          state_nxt = S_LOAD;
          after_nxt = AFT_OUT;
        end
      end

      S_LOAD: begin
        work_nxt  = chain_r;
        round_nxt = '0;
        state_nxt = S_ROUND;
      end

      S_ROUND: begin
        work_nxt[0] = work_r[3];
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[1] + rrot;
        round_nxt   = round_r + ROUND_W'(1);
        if (round_r == ROUND_LAST) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        unique case (after_r)
          AFT_IDLE: state_nxt = S_IDLE;
          AFT_PAD:  state_nxt = S_PAD;
          AFT_ZERO: begin
            state_nxt = S_ZERO;
            ptr_nxt   = '0;
          end
          AFT_OUT: begin
            state_nxt     = S_OUT;
            out_valid_nxt = 1'b1;
            out_idx_nxt   = '0;
          end
          default:  state_nxt = S_IDLE;
        endcase
      end

      S_OUT: begin
        if (out_fire) begin
          out_idx_nxt = out_idx_r + 2'd1;
          if (out_idx_r == WORD_IDX_LAST) begin
            // digest delivered: back to the initial chaining state
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
            chain_nxt[0]  = IV_A;
            chain_nxt[1]  = IV_B;
            chain_nxt[2]  = IV_C;
            chain_nxt[3]  = IV_D;
            count_nxt     = '0;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= AFT_IDLE;
      round_r     <= '0;
      ptr_r       <= '0;
      wrap_r      <= 1'b0;
      count_r     <= '0;
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      round_r     <= round_nxt;
      ptr_r       <= ptr_nxt;
      wrap_r      <= wrap_nxt;
      count_r     <= count_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr[BPTR_W-1:2]][{mem_waddr[1:0], 3'b000} +: BYTE_W] <= mem_wdata;
    end
    mem_rdata_r <= blk_mem[mem_raddr];
  end

endmodule

// ===== hdl/md5s_checker.sv =====
// ----------------------------------------------------------------------------
// md5s_checker: port-level checks for the MD5 stream hasher
// Watches the two channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module md5s_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [1:0]  out_word_index,
  input logic        out_final_word
);

  // stalled digest item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("digest item changed while stalled");

  // no new byte is taken while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  // digest words come out back to back in order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest word sequence broken");

  // last word flag only on word d
  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_word == (out_word_index == 2'd3)))
    else $error("final_word flag on wrong word");

  // after the last word the engine is ready for a new message
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final_word |=> in_ready && !out_valid)
    else $error("not ready after digest");

endmodule

bind md5_stream_hasher md5s_checker u_md5s_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_digest_word (out_bus.digest_word),
  .out_word_index  (out_bus.word_index),
  .out_final_word  (out_bus.final_word)
);

// ===== test/md5_stream_hasher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_test: self-checking bench for the streaming MD5 hasher
// Feeds messages one byte per item through the input channel and checks each
// digest word against an MD5 predictor in the bench or a typed-in digest. The directed rows
// come first, then random messages. The sender works in bursts with gaps, and
// the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module md5_stream_hasher_test;

  // random part stops once both targets are met
  localparam int ITEM_TARGET  = 330;
  localparam int MSG_TARGET   = 12;
  localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 250;   // two compressions plus padding
  localparam int DIR_ROWS     = 16;

  // well-known digests as {a, b, c, d}, each word little-endian
  localparam logic [127:0] MD5_EMPTY = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
  localparam logic [127:0] MD5_A     = 128'hb975c10c_a8b6f1c0_e299c331_61267769;
  localparam logic [127:0] MD5_ABC   = 128'h98500190_b04fd23c_7d3f96d6_727fe128;
  localparam logic [127:0] NO_DIGEST = 128'h0;

  // per-round additive constants and shift amounts
  localparam logic [0:63][31:0] SINE_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam logic [0:15][4:0] ROT_S = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // one directed row: the item to send and, where it ends a message whose
  // digest is well known, that digest typed in
  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         last;
    logic         typed;
    logic [127:0] digest;
  } dir_row_t;

  // one expected digest item
  typedef struct {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        is_last_word;
  } digest_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  md5s_in_if  in_ch ();
  md5s_out_if out_ch ();

  md5_stream_hasher dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // MD5 predictor state: chaining words, block buffer and byte count
  // --------------------------------------------------------------------------
  logic [31:0] chain_h [4];
  logic [7:0]  blk [64];
  logic [60:0] byte_cnt;
  logic [31:0] digest_out [4];

  digest_item_t expected_words [$];

  // sender-side info about the item on the bus, read when it is accepted
  logic         cur_typed  = 1'b0;
  logic [127:0] cur_digest = NO_DIGEST;

  int  fail_count   = 0;
  int  items_done   = 0;
  int  msgs_done    = 0;
  int  burst_left   = 0;
  bit  random_phase = 1'b0;

  dir_row_t dir_rows [DIR_ROWS];

  function automatic void chain_reset();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hefcdab89;
    chain_h[2] = 32'h98badcfe;
    chain_h[3] = 32'h10325476;
    byte_cnt   = '0;
  endfunction

  // 64 rounds over the current block, folded into the chaining words
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, sum, m;
    int          g;
    int unsigned s;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = r;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = 5 * r + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * r + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * r;
        end
      endcase
      g   = g % 16;
      m   = {blk[4*g+3], blk[4*g+2], blk[4*g+1], blk[4*g]};
      sum = a + f + SINE_K[r] + m;
      s   = ROT_S[(r / 16) * 4 + r % 4];
      a   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
  endfunction

  // absorbs one accepted item; returns 1 when a digest is ready in digest_out
  function automatic bit hash_item(logic [7:0] data, logic present, logic last);
    int          fill;
    logic [63:0] bit_len;
    if (present) begin
      blk[byte_cnt[5:0]] = data;
      byte_cnt = byte_cnt + 61'd1;
      if (byte_cnt[5:0] == 6'd0)
        md5_compress();
    end
    if (!last)
      return 1'b0;
    // padding: 0x80, zeros, then the bit length; may spill into a second block
    fill = int'(byte_cnt[5:0]);
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++)
        blk[i] = 8'h00;
      md5_compress();
      fill = 0;
    end
    for (int i = fill; i < 56; i++)
      blk[i] = 8'h00;
    bit_len = {byte_cnt, 3'b000};
    for (int i = 0; i < 8; i++)
      blk[56 + i] = bit_len[8*i +: 8];
    md5_compress();
    for (int k = 0; k < 4; k++)
      digest_out[k] = chain_h[k];
    chain_reset();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    digest_item_t w;
    if (rst_n) begin
      // an accepted end-of-message item queues four digest words
      if (in_ch.valid && in_ch.ready) begin
        if (hash_item(in_ch.message_byte, in_ch.byte_present, in_ch.end_of_message)) begin
          for (int k = 0; k < 4; k++) begin
            w.word         = cur_typed ? cur_digest[127 - 32*k -: 32] : digest_out[k];
            w.idx          = 2'(k);
            w.is_last_word = (k == 3);
            expected_words.insert(expected_words.size(), w);
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("digest item with nothing expected: word %h index %0d",
                 out_ch.digest_word, out_ch.word_index);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          if (out_ch.digest_word !== w.word) begin
            $error("digest_word: expected %h, got %h", w.word, out_ch.digest_word);
            fail_count++;
          end
          if (out_ch.word_index !== w.idx) begin
            $error("word_index: expected %0d, got %0d", w.idx, out_ch.word_index);
            fail_count++;
          end
          if (out_ch.final_word !== w.is_last_word) begin
            $error("final_word: expected %0b, got %0b", w.is_last_word, out_ch.final_word);
            fail_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: drive at the falling edge, hold until accepted, then either keep
  // the burst going or drop valid for a random gap
  // --------------------------------------------------------------------------
  task automatic offer(input logic [7:0] data, input logic present, input logic last,
                       input logic typed, input logic [127:0] digest);
    int gap;
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.message_byte   = data;
    in_ch.byte_present   = present;
    in_ch.end_of_message = last;
    cur_typed            = typed;
    cur_digest           = digest;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    items_done++;
    if (last)
      msgs_done++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid          = 1'b0;
      in_ch.message_byte   = 8'($urandom);
      in_ch.byte_present   = 1'($urandom);
      in_ch.end_of_message = 1'($urandom);
      repeat (gap - 1)
        @(negedge clk);
      // mostly short bursts, sometimes long stretches with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge; one long hold-off once the
  // random part starts, so the block holds its digest and stalls its input
  // --------------------------------------------------------------------------
  initial begin : receiver
    int seg_len;
    int mode;
    bit held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (random_phase && !held) begin
        held = 1'b1;
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1)
          @(negedge clk);
      end
      seg_len = $urandom_range(4, 40);
      mode    = $urandom_range(0, 2);
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = ($urandom_range(0, 3) != 0);
          default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int  pick;
    int  msg_len;
    bit  join_end;
    in_ch.valid          = 1'b0;
    in_ch.message_byte   = 8'h00;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    chain_reset();

    // directed rows: idle items, empty message, "a" with the end mark on the
    // byte, "abc" closed by a bare end marker, extreme byte values, and a
    // bare end marker whose byte field must be ignored
    dir_rows[0]  = '{8'ha5, 1'b0, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[1]  = '{8'h00, 1'b0, 1'b1, 1'b1, MD5_EMPTY};
    dir_rows[2]  = '{8'h61, 1'b1, 1'b1, 1'b1, MD5_A};
    dir_rows[3]  = '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[4]  = '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[5]  = '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[6]  = '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[7]  = '{8'hff, 1'b0, 1'b1, 1'b1, MD5_ABC};
    dir_rows[8]  = '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[9]  = '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[10] = '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[11] = '{8'h7f, 1'b1, 1'b1, 1'b0, NO_DIGEST};
    dir_rows[12] = '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST};
    dir_rows[13] = '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST};
    dir_rows[14] = '{8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST};
    dir_rows[15] = '{8'hff, 1'b0, 1'b1, 1'b1, MD5_EMPTY};

    repeat (3)
      @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      offer(dir_rows[i].data, dir_rows[i].present, dir_rows[i].last,
            dir_rows[i].typed, dir_rows[i].digest);

    // random messages: mostly short, many around the padding boundary at
    // 55/56 and 63/64 bytes, a few spanning two blocks; idle items mixed in
    items_done   = 0;
    msgs_done    = 0;
    random_phase = 1'b1;
    while (items_done < ITEM_TARGET || msgs_done < MSG_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)
        msg_len = $urandom_range(0, 12);
      else if (pick < 87)
        msg_len = $urandom_range(54, 66);
      else if (pick < 92)
        msg_len = $urandom_range(118, 130);
      else
        msg_len = $urandom_range(0, 3);
      join_end = (msg_len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 9) == 0)
          offer(8'($urandom), 1'b0, 1'b0, 1'b0, NO_DIGEST);
        offer(8'($urandom), 1'b1, join_end && (i == msg_len - 1), 1'b0, NO_DIGEST);
      end
      if (!join_end)
        offer(8'($urandom), 1'b0, 1'b1, 1'b0, NO_DIGEST);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    // drain, then give the block time to show any stray digest item
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES)
      @(posedge clk);

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/md5s_pkg.sv
hdl/md5s_in_if.sv
hdl/md5s_out_if.sv
hdl/md5_stream_hasher.sv
hdl/md5s_checker.sv
test/md5_stream_hasher_test.sv
